// ===== hdl/source_text_tokenizer_macros.svh =====
// Assertion macros shared by the tokenizer RTL.
`ifndef SOURCE_TEXT_TOKENIZER_MACROS_SVH
`define SOURCE_TEXT_TOKENIZER_MACROS_SVH

// Check a property at every rising clock edge.
`define STT_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

// Check a property outside of reset.
`define STT_ASSERT(label, prop, msg) \
  `STT_ASSERT_ALWAYS(label, disable iff (!rst_ni) prop, msg)

`endif

// ===== hdl/stt_pkg.sv =====
// Types, character codes and keyword table of the source text tokenizer.
`timescale 1ns / 1ps
package stt_pkg;

  typedef enum logic [3:0] {
    MODE_IDLE    = 4'd0,
    MODE_IDENT   = 4'd1,
    MODE_NUM     = 4'd2,
    MODE_NUMDOT  = 4'd3,
    MODE_FRAC    = 4'd4,
    MODE_STR     = 4'd5,
    MODE_ESC     = 4'd6,
    MODE_MINUS   = 4'd7,
    MODE_EQUAL   = 4'd8,
    MODE_SLASH   = 4'd9,
    MODE_COMMENT = 4'd10
  } scan_mode_e;

  typedef enum logic [2:0] {
    TK_KEYWORD = 3'd0,
    TK_IDENT   = 3'd1,
    TK_NUMBER  = 3'd2,
    TK_STRING  = 3'd3,
    TK_SYMBOL  = 3'd4,
    TK_EOF     = 3'd5
  } token_kind_e;

  typedef enum logic {
    ITEM_BYTE = 1'b0,
    ITEM_END  = 1'b1
  } item_kind_e;

  typedef struct packed {
    logic       kind;
    logic [7:0] byte_value;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  token_kind;
    logic [23:0] start_offset;
    logic [23:0] lexeme_length;
    logic [23:0] line_number;
    logic [7:0]  first_byte;
    logic        last_of_run;
  } token_t;

  localparam int MAX_RES         = 3;
  localparam int RES_QUEUE_DEPTH = 4;
  localparam int FIELD_WIDTH     = 24;

  localparam logic [7:0] CH_TAB    = 8'h09;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_SPACE  = 8'h20;
  localparam logic [7:0] CH_QUOTE  = 8'h22;
  localparam logic [7:0] CH_MINUS  = 8'h2D;
  localparam logic [7:0] CH_DOT    = 8'h2E;
  localparam logic [7:0] CH_SLASH  = 8'h2F;
  localparam logic [7:0] CH_DIG0   = 8'h30;
  localparam logic [7:0] CH_DIG9   = 8'h39;
  localparam logic [7:0] CH_EQ     = 8'h3D;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_BSLASH = 8'h5C;
  localparam logic [7:0] CH_UNDER  = 8'h5F;
  localparam logic [7:0] CH_LO_A   = 8'h61;
  localparam logic [7:0] CH_LO_Z   = 8'h7A;

  localparam int KW_NUM     = 11;
  localparam int KW_LEN_MAX = 6;

  localparam logic [7:0] KW_TEXT [KW_NUM][KW_LEN_MAX] = '{
    '{"m", "o", "d", "u", "l", "e"},
    '{"f", "u", "n", "c", 8'h00, 8'h00},
    '{"c", "l", "a", "s", "s", 8'h00},
    '{"v", "a", "r", 8'h00, 8'h00, 8'h00},
    '{"i", "f", 8'h00, 8'h00, 8'h00, 8'h00},
    '{"e", "l", "s", "e", 8'h00, 8'h00},
    '{"l", "o", "o", "p", 8'h00, 8'h00},
    '{"u", "n", "s", "a", "f", "e"},
    '{"r", "e", "t", "u", "r", "n"},
    '{"t", "r", "u", "e", 8'h00, 8'h00},
    '{"f", "a", "l", "s", "e", 8'h00}
  };

  localparam logic [4:0] KW_LEN [KW_NUM] = '{
    5'd6, 5'd4, 5'd5, 5'd3, 5'd2, 5'd4, 5'd4, 5'd6, 5'd6, 5'd4, 5'd5
  };

endpackage

// ===== hdl/stt_scan.sv =====
// Scanner core: scan state, keyword match and the results of one accepted beat.
`timescale 1ns / 1ps
`include "source_text_tokenizer_macros.svh"
module stt_scan
  import stt_pkg::*;
#(
  parameter int POS_WIDTH       = 24,
  parameter int KEYWORD_MAX_LEN = 6
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       fire_i,
  input  in_item_t   item_i,
  output token_t     res_o [MAX_RES],
  output logic [1:0] res_n_o
);

  localparam int SEEN_W = $clog2(KEYWORD_MAX_LEN + 2);
  localparam logic [POS_WIDTH-1:0] POS_ONE = {{(POS_WIDTH-1){1'b0}}, 1'b1};

  scan_mode_e            mode_q, mode_d;
  logic [POS_WIDTH-1:0]  start_q, start_d;
  logic [POS_WIDTH-1:0]  pos_q, pos_d;
  logic [POS_WIDTH-1:0]  line_q, line_d;
  logic [SEEN_W-1:0]     seen_q, seen_d;
  logic [7:0]            prefix_q [KEYWORD_MAX_LEN];

  logic       keep_en, pref0_en;
  logic       is_byte, go_idle, kw_hit;
  logic       b_space, b_digit, b_alpha, b_plain;
  logic [7:0] b;
  logic [POS_WIDTH-1:0] p, p_prev, p_next;

  function automatic logic [POS_WIDTH-1:0] sat_inc(input logic [POS_WIDTH-1:0] v);
    return (v == '1) ? v : v + POS_ONE;
  endfunction

  function automatic logic [FIELD_WIDTH-1:0] to_field(input logic [POS_WIDTH-1:0] v);
    logic [POS_WIDTH+FIELD_WIDTH-1:0] e;
    e = {{FIELD_WIDTH{1'b0}}, v};
    return e[FIELD_WIDTH-1:0];
  endfunction

  function automatic token_t mk_tok(input token_kind_e kind, input logic [POS_WIDTH-1:0] off,
                                    input logic [POS_WIDTH-1:0] len,
                                    input logic [POS_WIDTH-1:0] line, input logic [7:0] first);
    token_t t;
    t.token_kind    = kind;
    t.start_offset  = to_field(off);
    t.lexeme_length = to_field(len);
    t.line_number   = to_field(line);
    t.first_byte    = first;
    t.last_of_run   = 1'b0;
    return t;
  endfunction

  assign b       = item_i.byte_value;
  assign is_byte = item_i.kind == ITEM_BYTE;
  assign p       = pos_q;
  assign p_prev  = pos_q - POS_ONE;
  assign p_next  = sat_inc(pos_q);
  assign b_space = (b == CH_SPACE) || (b inside {[CH_TAB:CH_CR]});
  assign b_digit = b inside {[CH_DIG0:CH_DIG9]};
  assign b_alpha = (b inside {[CH_LO_A:CH_LO_Z]}) || (b inside {[CH_UP_A:CH_UP_Z]}) ||
                   (b == CH_UNDER);
  assign b_plain = !b_space && !b_digit && !b_alpha && (b != CH_SLASH) &&
                   (b != CH_MINUS) && (b != CH_EQ) && (b != CH_QUOTE);

  // Keyword compare against all table entries in parallel.
  always_comb begin
    logic match;
    kw_hit = 1'b0;
    for (int k = 0; k < KW_NUM; k++) begin
      match = int'(seen_q) == int'(KW_LEN[k]);
      for (int i = 0; i < KW_LEN_MAX; i++) begin
        if (i < int'(KW_LEN[k]) && prefix_q[i] != KW_TEXT[k][i]) begin
          match = 1'b0;
        end
      end
      if (match) begin
        kw_hit = 1'b1;
      end
    end
  end

  // The byte ends the current token and is scanned again from idle.
  always_comb begin
    go_idle = 1'b0;
    case (mode_q)
      MODE_IDENT:   go_idle = !(b_alpha || b_digit);
      MODE_NUM:     go_idle = !b_digit && (b != CH_DOT);
      MODE_NUMDOT:  go_idle = !b_digit;
      MODE_FRAC:    go_idle = !b_digit;
      MODE_MINUS:   go_idle = b != CH_GT;
      MODE_EQUAL:   go_idle = b != CH_EQ;
      MODE_SLASH:   go_idle = b != CH_SLASH;
      MODE_STR, MODE_ESC, MODE_COMMENT: go_idle = 1'b0;
      default:      go_idle = 1'b1;
    endcase
  end

  // Next state.
  always_comb begin
    mode_d   = mode_q;
    start_d  = start_q;
    pos_d    = pos_q;
    line_d   = line_q;
    seen_d   = seen_q;
    keep_en  = 1'b0;
    pref0_en = 1'b0;
    if (fire_i) begin
      if (!is_byte) begin
        mode_d  = MODE_IDLE;
        start_d = '0;
        pos_d   = '0;
        line_d  = POS_ONE;
        seen_d  = '0;
      end else begin
        pos_d = p_next;
        if (b == CH_LF) begin
          line_d = sat_inc(line_q);
        end
        case (mode_q)
          MODE_IDENT: keep_en = b_alpha || b_digit;
          MODE_NUM: begin
            if (b == CH_DOT) mode_d = MODE_NUMDOT;
          end
          MODE_NUMDOT: begin
            if (b_digit) mode_d = MODE_FRAC;
          end
          MODE_STR: begin
            if (b == CH_QUOTE) begin
              mode_d = MODE_IDLE;
            end else begin
              keep_en = 1'b1;
              if (b == CH_BSLASH) mode_d = MODE_ESC;
            end
          end
          MODE_ESC: begin
            keep_en = 1'b1;
            mode_d  = MODE_STR;
          end
          MODE_MINUS: begin
            if (b == CH_GT) mode_d = MODE_IDLE;
          end
          MODE_EQUAL: begin
            if (b == CH_EQ) mode_d = MODE_IDLE;
          end
          MODE_SLASH: begin
            if (b == CH_SLASH) mode_d = MODE_COMMENT;
          end
          MODE_COMMENT: begin
            if (b == CH_LF) mode_d = MODE_IDLE;
          end
          default: ;
        endcase
        if (keep_en && int'(seen_q) <= KEYWORD_MAX_LEN) begin
          seen_d = seen_q + SEEN_W'(1);
        end
        if (go_idle) begin
          mode_d = MODE_IDLE;
          if (!b_space) begin
            start_d = p;
            seen_d  = '0;
            if (b == CH_SLASH) begin
              mode_d = MODE_SLASH;
            end else if (b == CH_MINUS) begin
              mode_d = MODE_MINUS;
            end else if (b == CH_EQ) begin
              mode_d = MODE_EQUAL;
            end else if (b == CH_QUOTE) begin
              mode_d  = MODE_STR;
              start_d = p_next;
            end else if (b_digit) begin
              mode_d   = MODE_NUM;
              pref0_en = 1'b1;
            end else if (b_alpha) begin
              mode_d   = MODE_IDENT;
              pref0_en = 1'b1;
              seen_d   = SEEN_W'(1);
            end
          end
        end
      end
    end
  end

  // Results of the beat, in order.
  always_comb begin
    logic [1:0] n;
    logic [7:0] str_first;
    n = 2'd0;
    str_first = (seen_q != '0) ? prefix_q[0] : 8'h00;
    for (int i = 0; i < MAX_RES; i++) begin
      res_o[i] = '0;
    end
    if (fire_i) begin
      if (!is_byte) begin
        case (mode_q)
          MODE_IDENT: begin
            res_o[n] = mk_tok(kw_hit ? TK_KEYWORD : TK_IDENT, start_q, p - start_q,
                              line_q, prefix_q[0]);
            n = n + 2'd1;
          end
          MODE_NUM, MODE_FRAC: begin
            res_o[n] = mk_tok(TK_NUMBER, start_q, p - start_q, line_q, prefix_q[0]);
            n = n + 2'd1;
          end
          MODE_NUMDOT: begin
            res_o[n] = mk_tok(TK_NUMBER, start_q, p_prev - start_q, line_q, prefix_q[0]);
            n = n + 2'd1;
            res_o[n] = mk_tok(TK_SYMBOL, p_prev, POS_ONE, line_q, CH_DOT);
            n = n + 2'd1;
          end
          MODE_STR, MODE_ESC: begin
            res_o[n] = mk_tok(TK_STRING, start_q, p - start_q, line_q, str_first);
            n = n + 2'd1;
          end
          MODE_MINUS: begin
            res_o[n] = mk_tok(TK_SYMBOL, start_q, POS_ONE, line_q, CH_MINUS);
            n = n + 2'd1;
          end
          MODE_EQUAL: begin
            res_o[n] = mk_tok(TK_SYMBOL, start_q, POS_ONE, line_q, CH_EQ);
            n = n + 2'd1;
          end
          MODE_SLASH: begin
            res_o[n] = mk_tok(TK_SYMBOL, start_q, POS_ONE, line_q, CH_SLASH);
            n = n + 2'd1;
          end
          default: ;
        endcase
        res_o[n] = mk_tok(TK_EOF, p, '0, line_q, 8'h00);
        n = n + 2'd1;
      end else begin
        case (mode_q)
          MODE_IDENT: begin
            if (go_idle) begin
              res_o[n] = mk_tok(kw_hit ? TK_KEYWORD : TK_IDENT, start_q, p - start_q,
                                line_q, prefix_q[0]);
              n = n + 2'd1;
            end
          end
          MODE_NUM, MODE_FRAC: begin
            if (go_idle) begin
              res_o[n] = mk_tok(TK_NUMBER, start_q, p - start_q, line_q, prefix_q[0]);
              n = n + 2'd1;
            end
          end
          MODE_NUMDOT: begin
            if (go_idle) begin
              res_o[n] = mk_tok(TK_NUMBER, start_q, p_prev - start_q, line_q, prefix_q[0]);
              n = n + 2'd1;
              res_o[n] = mk_tok(TK_SYMBOL, p_prev, POS_ONE, line_q, CH_DOT);
              n = n + 2'd1;
            end
          end
          MODE_STR: begin
            if (b == CH_QUOTE) begin
              res_o[n] = mk_tok(TK_STRING, start_q, p - start_q, line_q, str_first);
              n = n + 2'd1;
            end
          end
          MODE_MINUS: begin
            res_o[n] = mk_tok(TK_SYMBOL, start_q, go_idle ? POS_ONE : POS_ONE + POS_ONE,
                              line_q, CH_MINUS);
            n = n + 2'd1;
          end
          MODE_EQUAL: begin
            res_o[n] = mk_tok(TK_SYMBOL, start_q, go_idle ? POS_ONE : POS_ONE + POS_ONE,
                              line_q, CH_EQ);
            n = n + 2'd1;
          end
          MODE_SLASH: begin
            if (go_idle) begin
              res_o[n] = mk_tok(TK_SYMBOL, start_q, POS_ONE, line_q, CH_SLASH);
              n = n + 2'd1;
            end
          end
          default: ;
        endcase
        if (go_idle && b_plain) begin
          res_o[n] = mk_tok(TK_SYMBOL, p, POS_ONE, line_q, b);
          n = n + 2'd1;
        end
      end
    end
    if (n != 2'd0) begin
      res_o[n - 2'd1].last_of_run = 1'b1;
    end
    res_n_o = n;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= MODE_IDLE;
      start_q <= '0;
      pos_q   <= '0;
      line_q  <= POS_ONE;
      seen_q  <= '0;
    end else begin
      mode_q  <= mode_d;
      start_q <= start_d;
      pos_q   <= pos_d;
      line_q  <= line_d;
      seen_q  <= seen_d;
    end
  end

  // Prefix bytes carry no reset; only entries below the byte count are compared.
  always_ff @(posedge clk_i) begin
    for (int i = 0; i < KEYWORD_MAX_LEN; i++) begin
      if ((pref0_en && i == 0) || (keep_en && int'(seen_q) == i)) begin
        prefix_q[i] <= b;
      end
    end
  end

  `STT_ASSERT(a_eof_restart, fire_i && item_i.kind == ITEM_END |=> pos_q == '0 && line_q == POS_ONE && mode_q == MODE_IDLE, "scan counters not restarted after end beat")
  `STT_ASSERT(a_end_emits, fire_i && item_i.kind == ITEM_END |-> res_n_o != 2'd0, "end beat produced no token")

endmodule

// ===== hdl/stt_res_queue.sv =====
// Result queue: takes up to three tokens per cycle and hands out one per beat.
`timescale 1ns / 1ps
`include "source_text_tokenizer_macros.svh"
module stt_res_queue
  import stt_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  token_t     push_data_i [MAX_RES],
  input  logic [1:0] push_n_i,
  output logic       space_o,
  output logic       valid_o,
  input  logic       pop_i,
  output token_t     data_o
);

  localparam int CNT_W = $clog2(RES_QUEUE_DEPTH + 1);

  token_t           slot_q [RES_QUEUE_DEPTH];
  token_t           slot_d [RES_QUEUE_DEPTH];
  logic [CNT_W-1:0] count_q, count_d, count_kept;

  assign valid_o = count_q != '0;
  assign data_o  = slot_q[0];
  // Room for a full burst of results, judged on the stored count only.
  assign space_o = int'(count_q) <= RES_QUEUE_DEPTH - MAX_RES;

  always_comb begin
    int j;
    count_kept = count_q - CNT_W'(pop_i);
    count_d    = count_kept + CNT_W'(push_n_i);
    for (int i = 0; i < RES_QUEUE_DEPTH; i++) begin
      if (pop_i && i < RES_QUEUE_DEPTH - 1) begin
        slot_d[i] = slot_q[(i + 1) % RES_QUEUE_DEPTH];
      end else begin
        slot_d[i] = slot_q[i];
      end
      j = i - int'(count_kept);
      if (j >= 0 && j < int'(push_n_i)) begin
        slot_d[i] = push_data_i[2'(j)];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    slot_q <= slot_d;
  end

  `STT_ASSERT(a_count_bound, int'(count_q) <= RES_QUEUE_DEPTH, "result queue overfilled")
  `STT_ASSERT(a_pop_nonempty, pop_i |-> count_q != '0, "pop from empty result queue")
  `STT_ASSERT(a_count_track, 1'b1 |=> int'(count_q) == int'($past(count_q)) - int'($past(pop_i)) + int'($past(push_n_i)), "result queue count lost a beat")

endmodule

// ===== hdl/source_text_tokenizer.sv =====
// Source text tokenizer: streaming lexical scanner, top level.
//
// Input channel (in_valid_i / in_ready_o / in_data_i) takes one beat per
// source byte, kind 0, and a beat of kind 1 that closes the source. Output
// channel (out_valid_o / out_ready_i / out_data_o) delivers tokens one per
// beat; last_of_run marks the final token caused by an input beat.
// Each accepted byte is scanned in the cycle it is taken: mode, counters and
// keyword prefix update at that edge and its tokens enter a four-entry
// result queue, which registers them before they reach the output.
// Throughput is one input beat per cycle while each beat yields at most one
// token and the receiver takes every token; a beat that yields two or three
// tokens hands them out one per output beat.
// in_ready_o is high while the queue holds at most one token, so a stalled
// receiver holds tokens in the queue and the input backs up after one more.
// Reset clears the scan mode, offsets and queue; line count restarts at one.
// An end beat flushes the pending token, emits the end-of-file token and
// restarts the counters. Byte offset and line count saturate.
`timescale 1ns / 1ps
module source_text_tokenizer
  import stt_pkg::*;
#(
  parameter int POS_WIDTH       = 24,
  parameter int KEYWORD_MAX_LEN = 6
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  input  in_item_t in_data_i,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output token_t   out_data_o
);

  token_t     res [MAX_RES];
  logic [1:0] res_n;
  logic       fire, space;

  assign in_ready_o = space;
  assign fire       = in_valid_i && space;

  stt_scan #(
    .POS_WIDTH      (POS_WIDTH),
    .KEYWORD_MAX_LEN(KEYWORD_MAX_LEN)
  ) u_scan (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (fire),
    .item_i (in_data_i),
    .res_o  (res),
    .res_n_o(res_n)
  );

  stt_res_queue u_queue (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_data_i(res),
    .push_n_i   (res_n),
    .space_o    (space),
    .valid_o    (out_valid_o),
    .pop_i      (out_valid_o && out_ready_i),
    .data_o     (out_data_o)
  );

endmodule

// ===== tb/tb.sv =====
// Self-checking testbench for the source text tokenizer.
`timescale 1ns / 1ps
module tb
  import stt_pkg::*;
();

  localparam int          CYCLE_LIMIT = 200000;
  localparam int          DRAIN_WAIT  = 20;
  localparam int          RAND_BEATS  = 125;
  localparam int          SHOW_MAX    = 10;
  localparam logic [7:0]  CH_VT       = 8'h0B;
  localparam logic [7:0]  CH_FF       = 8'h0C;
  localparam logic [7:0]  WS_SET [6]  = '{CH_SPACE, CH_TAB, CH_LF, CH_CR, CH_VT, CH_FF};

  class token_scoreboard;
    scan_mode_e             mode;
    logic [FIELD_WIDTH-1:0] tok_start;
    logic [FIELD_WIDTH-1:0] byte_pos;
    logic [FIELD_WIDTH-1:0] line_cnt;
    logic [7:0]             prefix [KW_LEN_MAX];
    int unsigned            seen;
    token_t                 due_q  [$];
    token_t                 step_q [$];
    int                     err_cnt;

    function new();
      mode      = MODE_IDLE;
      tok_start = '0;
      byte_pos  = '0;
      line_cnt  = FIELD_WIDTH'(1);
      seen      = 0;
      err_cnt   = 0;
      foreach (prefix[i]) prefix[i] = '0;
    endfunction

    static function logic [FIELD_WIDTH-1:0] sat_inc(logic [FIELD_WIDTH-1:0] v);
      return (&v) ? v : v + 1'b1;
    endfunction

    static function bit is_space(logic [7:0] b);
      return b == CH_SPACE || (b >= CH_TAB && b <= CH_CR);
    endfunction

    static function bit is_digit(logic [7:0] b);
      return b >= CH_DIG0 && b <= CH_DIG9;
    endfunction

    static function bit is_alpha(logic [7:0] b);
      return (b >= CH_LO_A && b <= CH_LO_Z) || (b >= CH_UP_A && b <= CH_UP_Z) ||
             b == CH_UNDER;
    endfunction

    function void put(token_kind_e k, logic [FIELD_WIDTH-1:0] off,
                      logic [FIELD_WIDTH-1:0] len, logic [7:0] first);
      token_t t;
      t.token_kind    = k;
      t.start_offset  = off;
      t.lexeme_length = len;
      t.line_number   = line_cnt;
      t.first_byte    = first;
      t.last_of_run   = 1'b0;
      step_q.push_back(t);
    endfunction

    function void keep(logic [7:0] b);
      if (seen < KW_LEN_MAX) prefix[seen] = b;
      if (seen <= KW_LEN_MAX) seen++;
    endfunction

    function void put_word(logic [FIELD_WIDTH-1:0] p);
      token_kind_e k;
      bit          hit;
      k = TK_IDENT;
      for (int w = 0; w < KW_NUM; w++) begin
        if (KW_LEN[w] != seen) continue;
        hit = 1'b1;
        for (int i = 0; i < KW_LEN[w]; i++)
          if (prefix[i] != KW_TEXT[w][i]) hit = 1'b0;
        if (hit) begin
          k = TK_KEYWORD;
          break;
        end
      end
      put(k, tok_start, p - tok_start, prefix[0]);
    endfunction

    function void put_string(logic [FIELD_WIDTH-1:0] p);
      put(TK_STRING, tok_start, p - tok_start, (seen != 0) ? prefix[0] : 8'h00);
    endfunction

    function void put_number(logic [FIELD_WIDTH-1:0] p);
      put(TK_NUMBER, tok_start, p - tok_start, prefix[0]);
    endfunction

    // Number followed by a lone dot: the dot sits one byte back.
    function void put_dot_split(logic [FIELD_WIDTH-1:0] p);
      logic [FIELD_WIDTH-1:0] dot_p;
      dot_p = p - 1'b1;
      put_number(dot_p);
      put(TK_SYMBOL, dot_p, FIELD_WIDTH'(1), CH_DOT);
    endfunction

    function void start_token(logic [7:0] b, logic [FIELD_WIDTH-1:0] p);
      mode = MODE_IDLE;
      if (is_space(b)) return;
      tok_start = p;
      seen      = 0;
      if (b == CH_SLASH) mode = MODE_SLASH;
      else if (b == CH_MINUS) mode = MODE_MINUS;
      else if (b == CH_EQ) mode = MODE_EQUAL;
      else if (b == CH_QUOTE) begin
        mode      = MODE_STR;
        tok_start = sat_inc(p);
      end else if (is_digit(b)) begin
        mode      = MODE_NUM;
        prefix[0] = b;
      end else if (is_alpha(b)) begin
        mode = MODE_IDENT;
        keep(b);
      end else put(TK_SYMBOL, p, FIELD_WIDTH'(1), b);
    endfunction

    // Two-byte symbol when the closer follows, else the lead byte alone.
    function void put_pair(logic [7:0] lead, logic [7:0] closer, logic [7:0] b,
                           logic [FIELD_WIDTH-1:0] p);
      if (b == closer) begin
        put(TK_SYMBOL, tok_start, FIELD_WIDTH'(2), lead);
        mode = MODE_IDLE;
      end else begin
        put(TK_SYMBOL, tok_start, FIELD_WIDTH'(1), lead);
        start_token(b, p);
      end
    endfunction

    function void note_item(in_item_t it);
      logic [7:0]             b;
      logic [FIELD_WIDTH-1:0] p;
      b = it.byte_value;
      p = byte_pos;
      step_q.delete();
      if (it.kind == ITEM_END) begin
        case (mode)
          MODE_IDENT:            put_word(p);
          MODE_NUM, MODE_FRAC:   put_number(p);
          MODE_NUMDOT:           put_dot_split(p);
          MODE_STR, MODE_ESC:    put_string(p);
          MODE_MINUS:            put(TK_SYMBOL, tok_start, FIELD_WIDTH'(1), CH_MINUS);
          MODE_EQUAL:            put(TK_SYMBOL, tok_start, FIELD_WIDTH'(1), CH_EQ);
          MODE_SLASH:            put(TK_SYMBOL, tok_start, FIELD_WIDTH'(1), CH_SLASH);
          default: ;
        endcase
        put(TK_EOF, p, '0, 8'h00);
        mode      = MODE_IDLE;
        tok_start = '0;
        byte_pos  = '0;
        line_cnt  = FIELD_WIDTH'(1);
        seen      = 0;
      end else begin
        case (mode)
          MODE_IDENT: begin
            if (is_alpha(b) || is_digit(b)) keep(b);
            else begin
              put_word(p);
              start_token(b, p);
            end
          end
          MODE_NUM: begin
            if (b == CH_DOT) mode = MODE_NUMDOT;
            else if (!is_digit(b)) begin
              put_number(p);
              start_token(b, p);
            end
          end
          MODE_NUMDOT: begin
            if (is_digit(b)) mode = MODE_FRAC;
            else begin
              put_dot_split(p);
              start_token(b, p);
            end
          end
          MODE_FRAC: begin
            if (!is_digit(b)) begin
              put_number(p);
              start_token(b, p);
            end
          end
          MODE_STR: begin
            if (b == CH_QUOTE) begin
              put_string(p);
              mode = MODE_IDLE;
            end else begin
              keep(b);
              if (b == CH_BSLASH) mode = MODE_ESC;
            end
          end
          MODE_ESC: begin
            keep(b);
            mode = MODE_STR;
          end
          MODE_MINUS: put_pair(CH_MINUS, CH_GT, b, p);
          MODE_EQUAL: put_pair(CH_EQ, CH_EQ, b, p);
          MODE_SLASH: begin
            if (b == CH_SLASH) mode = MODE_COMMENT;
            else begin
              put(TK_SYMBOL, tok_start, FIELD_WIDTH'(1), CH_SLASH);
              start_token(b, p);
            end
          end
          MODE_COMMENT: if (b == CH_LF) mode = MODE_IDLE;
          default: start_token(b, p);
        endcase
        byte_pos = sat_inc(byte_pos);
        if (b == CH_LF) line_cnt = sat_inc(line_cnt);
      end
      if (step_q.size() != 0) step_q[$].last_of_run = 1'b1;
      foreach (step_q[i]) due_q.push_back(step_q[i]);
    endfunction

    function void check_token(token_t got);
      token_t want;
      if (due_q.size() == 0) begin
        err_cnt++;
        if (err_cnt <= SHOW_MAX)
          $display("unexpected token: kind %0d off %0d len %0d line %0d byte %02h last %0d",
                   got.token_kind, got.start_offset, got.lexeme_length,
                   got.line_number, got.first_byte, got.last_of_run);
        return;
      end
      want = due_q.pop_front();
      if (got.token_kind !== want.token_kind || got.start_offset !== want.start_offset ||
          got.lexeme_length !== want.lexeme_length ||
          got.line_number !== want.line_number || got.first_byte !== want.first_byte ||
          got.last_of_run !== want.last_of_run) begin
        err_cnt++;
        if (err_cnt <= SHOW_MAX) begin
          $display("token mismatch at %0t", $realtime);
          $display("  expected kind %0d off %0d len %0d line %0d byte %02h last %0d",
                   want.token_kind, want.start_offset, want.lexeme_length,
                   want.line_number, want.first_byte, want.last_of_run);
          $display("  actual   kind %0d off %0d len %0d line %0d byte %02h last %0d",
                   got.token_kind, got.start_offset, got.lexeme_length,
                   got.line_number, got.first_byte, got.last_of_run);
        end
      end
    endfunction
  endclass

  logic     clk_i       = 1'b0;
  logic     rst_ni      = 1'b0;
  logic     in_valid_i  = 1'b0;
  in_item_t in_data_i   = '0;
  logic     out_ready_i = 1'b0;
  logic     in_ready_o;
  logic     out_valid_o;
  token_t   out_data_o;

  token_scoreboard sb = new();
  in_item_t        src_q [$];
  int              cycle_cnt   = 0;
  int              stall_left  = 0;
  int              stall_style = 0;
  string           punct       = ";(){}+*.<>,[]!";

  source_text_tokenizer uut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (rst_ni && out_valid_o && out_ready_i) sb.check_token(out_data_o);
  end

  // Receiver: segments of free flow, random stalls, sparse pulses and hard stops.
  always @(negedge clk_i) begin
    if (stall_left == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_left  = $urandom_range(8, 40);
    end
    stall_left--;
    case (stall_style)
      0:       out_ready_i <= 1'b1;
      1:       out_ready_i <= ($urandom_range(0, 3) != 0);
      2:       out_ready_i <= (cycle_cnt % 5 == 0);
      default: out_ready_i <= 1'b0;
    endcase
  end

  initial begin
    while (cycle_cnt < CYCLE_LIMIT) @(posedge clk_i);
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  function automatic void add_byte(logic [7:0] b);
    in_item_t it;
    it.kind       = ITEM_BYTE;
    it.byte_value = b;
    src_q.push_back(it);
  endfunction

  function automatic void add_end();
    in_item_t it;
    it.kind       = ITEM_END;
    it.byte_value = 8'($urandom_range(0, 255));
    src_q.push_back(it);
  endfunction

  function automatic void add_text(string s);
    for (int i = 0; i < s.len(); i++) add_byte(s[i]);
  endfunction

  function automatic logic [7:0] word_char(bit lead);
    int r;
    r = $urandom_range(0, lead ? 52 : 62);
    if (r < 26) return 8'(CH_LO_A + r);
    if (r < 52) return 8'(CH_UP_A + r - 26);
    if (r == 52) return CH_UNDER;
    return 8'(CH_DIG0 + r - 53);
  endfunction

  function automatic logic [7:0] digit_char();
    return 8'(CH_DIG0 + $urandom_range(0, 9));
  endfunction

  function automatic logic [7:0] byte_other_than(logic [7:0] a, logic [7:0] b);
    logic [7:0] c;
    do c = 8'($urandom_range(0, 255)); while (c == a || c == b);
    return c;
  endfunction

  // Append one well-formed lexeme, some noise or an end item, plus an optional separator.
  function automatic void add_lexeme();
    int sel;
    int n;
    int k;
    sel = $urandom_range(0, 99);
    if (sel < 18) begin
      k = $urandom_range(0, KW_NUM - 1);
      n = KW_LEN[k];
      if ($urandom_range(0, 9) == 0) n--;
      for (int i = 0; i < n; i++) add_byte(KW_TEXT[k][i]);
      if ($urandom_range(0, 4) == 0) add_byte(word_char(1'b0));
    end else if (sel < 36) begin
      n = $urandom_range(1, 9);
      add_byte(word_char(1'b1));
      repeat (n - 1) add_byte(word_char(1'b0));
    end else if (sel < 50) begin
      repeat ($urandom_range(1, 4)) add_byte(digit_char());
      if ($urandom_range(0, 2) == 0) begin
        add_byte(CH_DOT);
        if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 3)) add_byte(digit_char());
      end
    end else if (sel < 62) begin
      add_byte(CH_QUOTE);
      repeat ($urandom_range(0, 7)) begin
        if ($urandom_range(0, 4) == 0) begin
          add_byte(CH_BSLASH);
          add_byte($urandom_range(0, 1) ? CH_QUOTE : 8'($urandom_range(0, 255)));
        end else add_byte(byte_other_than(CH_QUOTE, CH_BSLASH));
      end
      // Leave some strings open until the end of the source.
      if ($urandom_range(0, 6) == 0) add_end();
      else add_byte(CH_QUOTE);
    end else if (sel < 72) begin
      case ($urandom_range(0, 5))
        0:       add_text("->");
        1:       add_text("==");
        2:       add_byte(CH_MINUS);
        3:       add_byte(CH_EQ);
        4:       add_byte(CH_SLASH);
        default: add_byte(punct[$urandom_range(0, punct.len() - 1)]);
      endcase
    end else if (sel < 77) begin
      add_text("//");
      repeat ($urandom_range(0, 8)) add_byte(byte_other_than(CH_LF, CH_LF));
      add_byte(CH_LF);
    end else if (sel < 87) begin
      repeat ($urandom_range(1, 3)) add_byte(8'($urandom_range(0, 255)));
    end else if (sel < 92) begin
      add_end();
    end else begin
      repeat ($urandom_range(1, 3)) add_byte(WS_SET[$urandom_range(0, 5)]);
    end
    if ($urandom_range(0, 9) < 7) add_byte(WS_SET[$urandom_range(0, 5)]);
  endfunction

  task automatic send_item(in_item_t it);
    @(negedge clk_i);
    in_valid_i <= 1'b1;
    in_data_i  <= it;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    sb.note_item(it);
  endtask

  task automatic hold_off(int n);
    @(negedge clk_i);
    in_valid_i <= 1'b0;
    repeat (n - 1) @(negedge clk_i);
  endtask

  initial begin
    int burst_left;
    int gap;
    int n_directed;
    burst_left = 0;

    // End on an empty source, keyword cut by a quote, empty string,
    // number with a lone dot before a symbol, zero and high bytes,
    // a comment, a token ended by a line feed, both two-byte symbols,
    // and a number with a lone dot closed by the end item.
    add_end();
    add_text("if\"\"");
    add_text("7.+");
    add_byte(8'h00);
    add_byte(8'hFF);
    add_text("//x\n");
    add_text("a\n");
    add_text("->==");
    add_text("9.");
    add_end();
    n_directed = src_q.size();
    while (src_q.size() < n_directed + RAND_BEATS) add_lexeme();
    add_end();

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (src_q[i]) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap != 0) hold_off(gap);
        burst_left = $urandom_range(1, 24);
      end
      send_item(src_q[i]);
      burst_left--;
    end
    @(negedge clk_i);
    in_valid_i <= 1'b0;

    while (sb.due_q.size() != 0) @(posedge clk_i);
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (sb.err_cnt == 0 && sb.due_q.size() == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule

// ===== source_text_tokenizer.f =====
+incdir+hdl
hdl/stt_pkg.sv
hdl/stt_scan.sv
hdl/stt_res_queue.sv
hdl/source_text_tokenizer.sv
tb/tb.sv
